// File: rtl/core/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache simulator.
`default_nettype none
package salc_pkg;

   localparam int ADDR_W  = 64;
   // Set and block fields take at least one bit each, so a tag never exceeds this.
   localparam int TAG_W   = 62;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_FETCH  = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;    // capture item, read its set row
      logic exec;    // look up, write back, post the result
      logic csr_we;  // write a configuration register
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/core/salc_ctrl.sv
// Controller state machine for the cache simulator.
`default_nettype none
module salc_ctrl
   import salc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic csr_valid,
   output logic      busy,
   output logic      csr_ready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      csr_ready  = 1'b1;
      cmd.csr_we = csr_valid;
      busy       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/salc_dp.sv
// Datapath: configuration, set row memory, LRU lookup and running totals.
`default_nettype none
module salc_dp
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_hits_now,
   output logic                       rsp_miss_now,
   output logic                       rsp_evicted_now,
   output logic [31:0]                rsp_hit_total,
   output logic [31:0]                rsp_miss_total,
   output logic [31:0]                rsp_eviction_total
);

   localparam int SET_W    = MAX_SET_BITS;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W    = AGE_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
      logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
   } row_type;

   function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] inc);
      logic [32:0] sum;
      sum = {1'b0, v} + {31'b0, inc};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Configuration
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd1;
         block_bits_ff <= 6'd1;
         ways_ff       <= 4'd1;
      end else if (cmd.csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[5:0];
            CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            default:        ;
         endcase
      end
   end

   logic [2:0] s_eff;
   logic [5:0] b_eff;
   logic [3:0] nw_eff;

   always_comb begin
      s_eff = set_bits_ff;
      if (set_bits_ff == 3'd0) s_eff = 3'd1;
      else if (int'(set_bits_ff) > MAX_SET_BITS) s_eff = 3'(MAX_SET_BITS);
      b_eff = (block_bits_ff == 6'd0) ? 6'd1 : block_bits_ff;
      nw_eff = ways_ff;
      if (ways_ff == 4'd0) nw_eff = 4'd1;
      else if (int'(ways_ff) > MAX_WAYS) nw_eff = 4'(MAX_WAYS);
   end

   // Address split
   logic [ADDR_W-1:0] shifted;
   logic [TAG_W-1:0]  tag_wide;
   logic [SET_W-1:0]  rd_set;

   assign shifted  = req_address >> b_eff;
   assign tag_wide = TAG_W'(shifted >> s_eff);
   assign rd_set   = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);

   opcode_type        op_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;

   // Row memory; a row never written reads as all lines invalid, age zero
   row_type           row_mem [NUM_SETS];
   row_type           rd_row_ff;
   logic [NUM_SETS-1:0] row_valid_ff;
   logic              row_ok_ff;
   logic              wr_en;
   row_type           new_row;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_opcode);
         set_ff    <= rd_set;
         tag_ff    <= tag_wide;
         rd_row_ff <= row_mem[rd_set];
      end
      if (wr_en) begin
         row_mem[set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         row_ok_ff    <= 1'b0;
      end else begin
         if (cmd.load) row_ok_ff <= row_valid_ff[rd_set];
         if (wr_en) row_valid_ff[set_ff] <= 1'b1;
      end
   end

   // Lookup
   row_type             cur_row;
   logic [MAX_WAYS-1:0] active;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] inv_vec;
   logic                hit;
   logic                any_inv;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    inv_way;
   logic [WAY_W-1:0]    old_way;
   logic [AGE_W-1:0]    oldest;
   logic [WAY_W-1:0]    way_sel;
   logic [AGE_W-1:0]    ref_age;
   logic                ref_none;

   always_comb begin
      cur_row = rd_row_ff;
      if (!row_ok_ff) begin
         cur_row.valid = '0;
         cur_row.age   = '0;
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         active[i]  = i < int'(nw_eff);
         hit_vec[i] = active[i] && cur_row.valid[i] && (cur_row.tag[i] == tag_ff);
         inv_vec[i] = active[i] && !cur_row.valid[i];
      end
      hit     = |hit_vec;
      any_inv = |inv_vec;
      hit_way = '0;
      inv_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_way = WAY_W'(i);
         if (inv_vec[i]) inv_way = WAY_W'(i);
      end
      // first way holding the greatest age
      old_way = '0;
      oldest  = cur_row.age[0];
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (active[i] && cur_row.age[i] > oldest) begin
            oldest  = cur_row.age[i];
            old_way = WAY_W'(i);
         end
      end
      if (hit) way_sel = hit_way;
      else if (any_inv) way_sel = inv_way;
      else way_sel = old_way;
      ref_age  = cur_row.age[way_sel];
      ref_none = !hit && any_inv;

      new_row = cur_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (active[i] && cur_row.valid[i] && (WAY_W'(i) != way_sel) &&
             (ref_none || cur_row.age[i] < ref_age) && (cur_row.age[i] < AGE_MAX)) begin
            new_row.age[i] = cur_row.age[i] + AGE_W'(1);
         end
      end
      new_row.age[way_sel]   = '0;
      new_row.valid[way_sel] = 1'b1;
      if (!hit) new_row.tag[way_sel] = tag_ff;
   end

   // A modify repeats the lookup on the line just made most recent: one more hit.
   logic       do_access;
   logic [1:0] hit_inc;
   logic       miss_inc;
   logic       evict_inc;

   assign do_access = cmd.exec && (op_ff != OP_FETCH);
   assign wr_en     = do_access;
   assign hit_inc   = do_access ? ({1'b0, hit} + {1'b0, op_ff == OP_MODIFY}) : 2'd0;
   assign miss_inc  = do_access && !hit;
   assign evict_inc = do_access && !hit && !any_inv;

   logic [31:0] hits_ff, misses_ff, evicts_ff;
   logic [31:0] hits_in, misses_in, evicts_in;

   assign hits_in   = sat_add(hits_ff, hit_inc);
   assign misses_in = sat_add(misses_ff, {1'b0, miss_inc});
   assign evicts_in = sat_add(evicts_ff, {1'b0, evict_inc});

   logic       rsp_valid_ff;
   logic [1:0] rsp_hits_ff;
   logic       rsp_miss_ff;
   logic       rsp_evict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.exec) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
            evicts_ff <= evicts_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_hits_ff  <= hit_inc;
         rsp_miss_ff  <= miss_inc;
         rsp_evict_ff <= evict_inc;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hits_now       = rsp_hits_ff;
   assign rsp_miss_now       = rsp_miss_ff;
   assign rsp_evicted_now    = rsp_evict_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evicts_ff;

endmodule
`default_nettype wire

// File: rtl/core/set_associative_lru_cache_sim.sv
// Top level of the set-associative LRU cache hit/miss/eviction counter.
//
// Usage:
//   Drive req_opcode and req_address with start high; the item is taken at
//   the rising edge where start is high and busy is low. busy is high for
//   the one cycle in which the item is looked up.
//   In the cycle after that, rsp_valid is high for exactly one cycle with the
//   per-access counts and the running totals. The receiver cannot stall.
//   No new item is taken while busy is high. At the accepting edge the set
//   row is read from the row memory into a register; in the busy cycle the
//   tag compare, LRU update and row write-back follow. A modify needs no
//   extra state.
//   Configuration: write set_bits, block_bits, ways over csr_valid/csr_ready
//   (always ready) with csr_index and csr_wdata, while no item is in flight.
//   Reset (synchronous): cache empties at once via per-set valid flags, the
//   totals clear, registers return to 1, 1, 1. No clearing pass is needed.
`default_nettype none
module set_associative_lru_cache_sim
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [ADDR_W-1:0]     req_address,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_hits_now,
   output logic                       rsp_miss_now,
   output logic                       rsp_evicted_now,
   output logic [31:0]                rsp_hit_total,
   output logic [31:0]                rsp_miss_total,
   output logic [31:0]                rsp_eviction_total,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   salc_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req_opcode),
      .req_address        (req_address),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_hits_now       (rsp_hits_now),
      .rsp_miss_now       (rsp_miss_now),
      .rsp_evicted_now    (rsp_evicted_now),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule
`default_nettype wire

// File: tb/salc_checker.sv
// Scoreboard for the cache simulator: predicts per-access counts and totals, compares responses.
`timescale 1ns / 100ps
module salc_checker
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  rsp_valid,
   input  wire logic [1:0]            rsp_hits_now,
   input  wire logic                  rsp_miss_now,
   input  wire logic                  rsp_evicted_now,
   input  wire logic [31:0]           rsp_hit_total,
   input  wire logic [31:0]           rsp_miss_total,
   input  wire logic [31:0]           rsp_eviction_total,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   localparam int LINES   = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int AGE_TOP = MAX_WAYS - 1;
   // Age bound used when filling an empty line: every valid neighbor below AGE_TOP gets older.
   localparam int FILL_BOUND = 256;

   typedef struct packed {
      logic [1:0]  hits;
      logic        miss;
      logic        evicted;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] evict_total;
   } access_counts_type;

   logic             line_ok   [LINES];
   logic [TAG_W-1:0] line_label[LINES];
   int               line_rank [LINES];
   logic [31:0]      hit_sum, miss_sum, evict_sum;
   logic [2:0]       cfg_sets;
   logic [5:0]       cfg_block;
   logic [3:0]       cfg_ways;
   access_counts_type counts_due[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < 40) begin
         $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Make way w most recent; neighbors younger than bound age by one, up to AGE_TOP.
   task automatic refresh_age(input int base, input int nw, input int w, input int bound);
      for (int i = 0; i < nw; i++) begin
         if (i != w && line_ok[base+i] && line_rank[base+i] < bound &&
             line_rank[base+i] < AGE_TOP) begin
            line_rank[base+i]++;
         end
      end
      line_rank[base+w] = 0;
   endtask

   task automatic probe_set(input int base, input int nw, input logic [TAG_W-1:0] tag,
                            inout int h, inout int m, inout int e);
      int victim;
      int oldest;
      bit hole;
      victim = 0;
      oldest = 0;
      hole   = 1'b0;
      for (int i = 0; i < nw; i++) begin
         if (line_ok[base+i] && line_label[base+i] == tag) begin
            refresh_age(base, nw, i, line_rank[base+i]);
            h++;
            hit_sum = bump(hit_sum);
            return;
         end
      end
      m++;
      miss_sum = bump(miss_sum);
      for (int i = 0; i < nw; i++) begin
         if (!line_ok[base+i]) begin
            victim = i;
            hole   = 1'b1;
            break;
         end
         if (i == 0 || line_rank[base+i] > oldest) begin
            oldest = line_rank[base+i];
            victim = i;
         end
      end
      line_label[base+victim] = tag;
      if (hole) begin
         line_ok[base+victim] = 1'b1;
         refresh_age(base, nw, victim, FILL_BOUND);
      end else begin
         e++;
         evict_sum = bump(evict_sum);
         refresh_age(base, nw, victim, line_rank[base+victim]);
      end
   endtask

   task automatic predict_access(input opcode_type op, input logic [ADDR_W-1:0] addr,
                                 output access_counts_type c);
      int s, b, nw, base, h, m, e;
      logic [63:0] shifted, set_no;
      logic [TAG_W-1:0] tag;
      h = 0;
      m = 0;
      e = 0;
      if (op != OP_FETCH) begin
         s  = cfg_sets;
         b  = cfg_block;
         nw = cfg_ways;
         if (s < 1) s = 1;
         if (s > MAX_SET_BITS) s = MAX_SET_BITS;
         if (b < 1) b = 1;
         if (nw < 1) nw = 1;
         if (nw > MAX_WAYS) nw = MAX_WAYS;
         shifted = addr >> b;
         set_no  = shifted & ((64'd1 << s) - 64'd1);
         tag     = TAG_W'(shifted >> s);
         base    = int'(set_no) * MAX_WAYS;
         probe_set(base, nw, tag, h, m, e);
         // a modify writes back to the line it just looked up
         if (op == OP_MODIFY) probe_set(base, nw, tag, h, m, e);
      end
      c.hits        = h[1:0];
      c.miss        = m[0];
      c.evicted     = e[0];
      c.hit_total   = hit_sum;
      c.miss_total  = miss_sum;
      c.evict_total = evict_sum;
   endtask

   always @(posedge clock) begin
      access_counts_type want;
      if (reset) begin
         for (int k = 0; k < LINES; k++) begin
            line_ok[k]   = 1'b0;
            line_rank[k] = 0;
         end
         hit_sum   = '0;
         miss_sum  = '0;
         evict_sum = '0;
         cfg_sets  = 3'd1;
         cfg_block = 6'd1;
         cfg_ways  = 4'd1;
         counts_due.delete();
      end else begin
         if (rsp_valid) begin
            if (counts_due.size() == 0) begin
               report_mismatch("response with no access pending", rsp_hit_total, '0);
            end else begin
               want = counts_due.pop_front();
               if (rsp_hits_now != want.hits)
                  report_mismatch("hits_now", rsp_hits_now, want.hits);
               if (rsp_miss_now != want.miss)
                  report_mismatch("miss_now", rsp_miss_now, want.miss);
               if (rsp_evicted_now != want.evicted)
                  report_mismatch("evicted_now", rsp_evicted_now, want.evicted);
               if (rsp_hit_total != want.hit_total)
                  report_mismatch("hit_total", rsp_hit_total, want.hit_total);
               if (rsp_miss_total != want.miss_total)
                  report_mismatch("miss_total", rsp_miss_total, want.miss_total);
               if (rsp_eviction_total != want.evict_total)
                  report_mismatch("eviction_total", rsp_eviction_total, want.evict_total);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   cfg_sets  = csr_wdata[2:0];
               CSR_BLOCK_BITS: cfg_block = csr_wdata[5:0];
               CSR_WAYS:       cfg_ways  = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            predict_access(opcode_type'(req_opcode), req_address, want);
            counts_due.push_back(want);
         end
      end
      outstanding = counts_due.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the cache simulator: clock, reset, access stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
   import salc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 12;
   localparam int PHASE_ITEMS = 62;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic [1:0]            req_opcode  = '0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   logic        busy, csr_ready, rsp_valid, rsp_miss_now, rsp_evicted_now;
   logic [1:0]  rsp_hits_now;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_eviction_total;

   int mismatches;
   int outstanding;
   int cycles = 0;
   int idle_pct = 0;
   int block_eff = 1;
   int hot_count = POOL_SIZE;
   logic [ADDR_W-1:0] hot_lines[POOL_SIZE];

   set_associative_lru_cache_sim dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_hits_now(rsp_hits_now), .rsp_miss_now(rsp_miss_now),
      .rsp_evicted_now(rsp_evicted_now), .rsp_hit_total(rsp_hit_total),
      .rsp_miss_total(rsp_miss_total), .rsp_eviction_total(rsp_eviction_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   salc_checker u_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_hits_now(rsp_hits_now), .rsp_miss_now(rsp_miss_now),
      .rsp_evicted_now(rsp_evicted_now), .rsp_hit_total(rsp_hit_total),
      .rsp_miss_total(rsp_miss_total), .rsp_eviction_total(rsp_eviction_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .mismatches(mismatches), .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL set_associative_lru_cache_sim");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly reuse hot lines with a fresh block offset, so hits and evictions happen.
   function automatic logic [ADDR_W-1:0] pick_address();
      int roll;
      logic [ADDR_W-1:0] near, offs;
      roll = $urandom_range(99);
      near = hot_lines[$urandom_range(hot_count - 1)];
      offs = (64'd1 << block_eff) - 64'd1;
      if (roll < 70) return near ^ (rand64() & offs);
      if (roll < 82) return near ^ (64'd1 << $urandom_range(63));
      return rand64();
   endfunction

   function automatic opcode_type pick_opcode();
      if ($urandom_range(99) < 10) return OP_FETCH;
      return opcode_type'($urandom_range(2));
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Write all registers plus the unmapped index; hi fills the unused upper bits.
   task automatic set_geometry(input logic [2:0] sb, input logic [5:0] bb, input logic [3:0] wb,
                               input logic [7:0] hi);
      write_reg(CSR_SET_BITS, {hi[7:3], sb});
      write_reg(CSR_BLOCK_BITS, {hi[7:6], bb});
      write_reg(CSR_WAYS, {hi[7:4], wb});
      write_reg(CSR_UNMAPPED, hi ^ 8'h5A);
      csr_valid <= 1'b0;
      block_eff = (bb == 6'd0) ? 1 : int'(bb);
   endtask

   task automatic send_access(input opcode_type op, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_opcode  <= op;
      req_address <= addr;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off until every pending response has come back, then let the pipe settle.
   task automatic drain();
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [2:0] sb;
      logic [5:0] bb;
      logic [3:0] wb;
      logic [7:0] hi;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: two sets, one way, one offset bit
      send_access(OP_LOAD, 64'h0);
      send_access(OP_STORE, 64'h0);
      send_access(OP_LOAD, 64'h1);
      send_access(OP_MODIFY, 64'h0);
      send_access(OP_LOAD, 64'h4);
      send_access(OP_MODIFY, 64'h8);
      send_access(OP_LOAD, '1);
      send_access(OP_STORE, '1);
      send_access(OP_FETCH, 64'h0);
      send_access(OP_FETCH, '1);
      send_access(OP_LOAD, 64'h8000_0000_0000_0000);
      drain();

      // out-of-range values saturate; old lines stay in place
      set_geometry(3'd7, 6'd63, 4'd15, 8'hFF);
      send_access(OP_LOAD, '1);
      send_access(OP_LOAD, 64'h0);
      send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
      send_access(OP_STORE, 64'h8000_0000_0000_0000);
      drain();

      // zero values act as one
      set_geometry(3'd0, 6'd0, 4'd0, 8'h00);
      send_access(OP_LOAD, 64'h2);
      send_access(OP_LOAD, 64'h6);
      send_access(OP_MODIFY, 64'h2);
      send_access(OP_STORE, 64'h0);
      drain();

      set_geometry(3'd6, 6'd57, 4'd8, 8'h00);
      send_access(OP_LOAD, 64'h0);
      send_access(OP_LOAD, 64'h0200_0000_0000_0000);
      send_access(OP_LOAD, 64'h8000_0000_0000_0000);
      send_access(OP_MODIFY, 64'h01FF_FFFF_FFFF_FFFF);
      send_access(OP_FETCH, 64'h5555_5555_5555_5555);
      drain();

      for (int p = 0; p < 9; p++) begin
         idle_pct = (p < 3) ? 11 : (p < 6) ? 64 : 0;
         case (p)
            0: begin sb = 3'd1; bb = 6'd1;  wb = 4'd1;  end
            1: begin sb = 3'd2; bb = 6'd4;  wb = 4'd4;  end
            2: begin sb = 3'd6; bb = 6'd57; wb = 4'd8;  end
            3: begin sb = 3'd3; bb = 6'd5;  wb = 4'd2;  end
            4: begin sb = 3'd0; bb = 6'd0;  wb = 4'd0;  end
            5: begin sb = 3'd7; bb = 6'd63; wb = 4'd15; end
            6: begin sb = 3'd1; bb = 6'd3;  wb = 4'd8;  end
            7: begin sb = 3'($urandom); bb = 6'($urandom); wb = 4'($urandom); end
            default: begin sb = 3'd4; bb = 6'd2; wb = 4'd3; end
         endcase
         hi = (p % 2 == 1) ? 8'($urandom) : 8'h00;
         set_geometry(sb, bb, wb, hi);
         hot_count = $urandom_range(POOL_SIZE, 3);
         for (int i = 0; i < POOL_SIZE; i++) begin
            if (p == 0 || $urandom_range(1) == 1) hot_lines[i] = rand64();
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_access(pick_opcode(), pick_address());
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS set_associative_lru_cache_sim");
      end else begin
         $display("FAIL set_associative_lru_cache_sim");
      end
      $finish;
   end

endmodule
